### rtl/assert_macros.svh
// assertion macros for rtl files that check themselves; only the top level includes them
// every macro samples on clk and is switched off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every sampled edge
`define AST_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent at the same edge
`define AST_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/dapid_pkg.sv
// types and constants of the dual axis pid controller
// no dependencies; imported by every module of the block
`default_nettype none

package dapid_pkg;

    localparam int ERR_W      = 16;
    localparam int ACC_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS  = 8;

    localparam int TARGET_RESET = 120;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

    localparam int ERR_MAX = 32767;
    localparam int ERR_MIN = -32768;

    // 64*r/3 rounded down, the fraction bits for remainder r of a division by three
    localparam logic [5:0] FRAC_REM_ONE = 6'd21;
    localparam logic [5:0] FRAC_REM_TWO = 6'd42;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_TARGET_X     = 3'd3,
        REG_TARGET_Y     = 3'd4,
        REG_OUTPUT_LIMIT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic step_state;
        logic load_prod;
    } dapid_ctrl_t;

endpackage

`default_nettype wire

### rtl/dapid_err.sv
// per-axis error: (pixel - target) * 64 / 3 plus offset, saturated to q8.8
// depends on dapid_pkg
`default_nettype none

module dapid_err #(
    parameter int PIXEL_BITS = 10
) (
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic [PIXEL_BITS-1:0] target,
    input  logic signed [15:0]    offset,
    output logic signed [15:0]    err
);
    import dapid_pkg::*;

    localparam int DW     = PIXEL_BITS + 1;
    localparam int RSHIFT = PIXEL_BITS + 1;
    localparam logic [PIXEL_BITS-1:0] RECIP = PIXEL_BITS'((2 ** RSHIFT) / 3 + 1);
    localparam int MW     = PIXEL_BITS + 6;
    localparam int SW     = ((MW + 1 > ERR_W) ? MW + 1 : ERR_W) + 1;

    logic signed [DW-1:0]       diff;
    logic [PIXEL_BITS-1:0]      mag;
    logic [2*PIXEL_BITS-1:0]    prod;
    logic [PIXEL_BITS-2:0]      quo;
    logic [PIXEL_BITS:0]        three_q;
    logic [1:0]                 rem;
    logic [5:0]                 frac;
    logic [MW-1:0]              smag;
    logic signed [SW-1:0]       scaled;
    logic signed [SW-1:0]       sum;

    always_comb
    begin
        diff = $signed({1'b0, pixel}) - $signed({1'b0, target});
        mag  = diff[DW-1] ? PIXEL_BITS'(-diff) : diff[PIXEL_BITS-1:0];

        // mag / 3 by reciprocal multiply, exact over the pixel range
        prod    = mag * RECIP;
        quo     = prod[2*PIXEL_BITS-1:RSHIFT];
        three_q = {1'b0, quo, 1'b0} + {2'b00, quo};
        rem     = 2'({1'b0, mag} - three_q);

        case (rem)
            2'd1:    frac = FRAC_REM_ONE;
            2'd2:    frac = FRAC_REM_TWO;
            default: frac = 6'd0;
        endcase

        smag   = MW'({quo, 6'b000000}) + MW'(frac);
        scaled = diff[DW-1] ? -$signed(SW'(smag)) : $signed(SW'(smag));
        sum    = scaled + SW'(offset);

        if (sum > ERR_MAX)
            err = 16'sh7FFF;
        else if (sum < ERR_MIN)
            err = 16'sh8000;
        else
            err = sum[15:0];
    end

endmodule

`default_nettype wire

### rtl/dapid_integ.sv
// per-axis integral and previous-error state with saturating update
// depends on dapid_pkg
`default_nettype none

module dapid_integ (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dapid_pkg::dapid_ctrl_t        ctrl,
    input  logic signed [15:0]            err,
    output logic signed [31:0]            acc,
    output logic signed [16:0]            diff
);
    import dapid_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [ACC_W-1:0]  accum_reg;
    logic signed [ERR_W-1:0]  last_err_reg;
    logic signed [ACC_W+1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb
    begin
        acc_sum = (ACC_W+2)'(accum_reg) + (ACC_W+2)'(err) + (ACC_W+2)'(last_err_reg);
        if (acc_sum > (ACC_W+2)'(ACC_MAX))
            acc_next = ACC_MAX;
        else if (acc_sum < (ACC_W+2)'(ACC_MIN))
            acc_next = ACC_MIN;
        else
            acc_next = acc_sum[ACC_W-1:0];
        acc  = acc_next;
        diff = (ERR_W+1)'(err) - (ERR_W+1)'(last_err_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg    <= '0;
            last_err_reg <= '0;
        end
        else if (ctrl.step_state)
        begin
            accum_reg    <= acc_next;
            last_err_reg <= err;
        end
    end

endmodule

`default_nettype wire

### rtl/dapid_drive.sv
// per-axis gain products, q8.8 rescale with floor, and symmetric clamp
// depends on dapid_pkg
`default_nettype none

module dapid_drive (
    input  logic                          clk,
    input  dapid_pkg::dapid_ctrl_t        ctrl,
    input  logic signed [15:0]            gain_p,
    input  logic signed [15:0]            gain_i,
    input  logic signed [15:0]            gain_d,
    input  logic signed [15:0]            err,
    input  logic signed [31:0]            acc,
    input  logic signed [16:0]            diff,
    input  logic [14:0]                   limit,
    output logic signed [15:0]            drive
);
    import dapid_pkg::*;

    localparam int P_W = GAIN_W + ERR_W;
    localparam int I_W = GAIN_W + ACC_W;
    localparam int D_W = GAIN_W + ERR_W + 1;
    localparam int S_W = I_W + 1;
    localparam int Q_W = S_W - FRAC_BITS;

    logic signed [P_W-1:0] prod_p_reg;
    logic signed [I_W-1:0] prod_i_reg;
    logic signed [D_W-1:0] prod_d_reg;
    logic signed [S_W-1:0] sum;
    logic signed [Q_W-1:0] scaled;
    logic signed [Q_W-1:0] lim_pos;
    logic signed [Q_W-1:0] lim_neg;
    logic signed [Q_W-1:0] clamped;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            prod_p_reg <= P_W'(gain_p) * P_W'(err);
            prod_i_reg <= I_W'(gain_i) * I_W'(acc);
            prod_d_reg <= D_W'(gain_d) * D_W'(diff);
        end
    end

    always_comb
    begin
        sum     = S_W'(prod_p_reg) + S_W'(prod_i_reg) + S_W'(prod_d_reg);
        // dropping the low bits of a two's complement value rounds toward minus infinity
        scaled  = $signed(sum[S_W-1:FRAC_BITS]);
        lim_pos = $signed(Q_W'(limit));
        lim_neg = -lim_pos;
        if (scaled <= lim_neg)
            clamped = lim_neg;
        else if (scaled >= lim_pos)
            clamped = lim_pos;
        else
            clamped = scaled;
        drive = clamped[DRIVE_W-1:0];
    end

endmodule

`default_nettype wire

### rtl/dual_axis_pid_controller.sv
// top level of the dual axis pid controller: config registers, pipeline control
// depends on dapid_pkg, dapid_err, dapid_integ, dapid_drive and assert_macros.svh
//
// Two-axis PID regulator. Each transaction on the item channel carries the
// measured ball pixel position and a Q8.8 setpoint offset per axis; each
// transaction on the result channel carries the clamped Q8.8 drive for both
// axes, one result per item, in order. The pipeline has five register stages
// (input, error, integral, products, output). The input stage loads at the
// edge that accepts the item, then the error, integral, products and output
// registers in turn. One item can be accepted every cycle while item ready
// is high; the per-item rate is set by the integral stage, whose saturating
// accumulate and previous-error update close a feedback loop. Ready on the
// item channel drops only when every stage holds an item and the output is
// not being taken. The configuration channel is always ready; write it only
// when the pipeline is empty. Unknown register indexes are ignored.
`default_nettype none

`include "assert_macros.svh"

module dual_axis_pid_controller #(
    parameter int PIXEL_BITS = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [15:0]               cfg_data,

    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic [PIXEL_BITS-1:0]     ball_x,
    input  logic [PIXEL_BITS-1:0]     ball_y,
    input  logic signed [15:0]        offset_x,
    input  logic signed [15:0]        offset_y,

    output logic                      result_valid,
    input  logic                      result_ready,
    output logic signed [15:0]        drive_x,
    output logic signed [15:0]        drive_y
);
    import dapid_pkg::*;

    // configuration
    logic signed [GAIN_W-1:0]  gain_p_reg;
    logic signed [GAIN_W-1:0]  gain_i_reg;
    logic signed [GAIN_W-1:0]  gain_d_reg;
    logic [PIXEL_BITS-1:0]     target_x_reg;
    logic [PIXEL_BITS-1:0]     target_y_reg;
    logic [LIMIT_W-1:0]        limit_reg;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic v1_next, v2_next, v3_next, v4_next, out_valid_next;

    // stage payloads
    logic [PIXEL_BITS-1:0]     ball_x_reg;
    logic [PIXEL_BITS-1:0]     ball_y_reg;
    logic signed [ERR_W-1:0]   offset_x_reg;
    logic signed [ERR_W-1:0]   offset_y_reg;
    logic signed [ERR_W-1:0]   err2_x_reg;
    logic signed [ERR_W-1:0]   err2_y_reg;
    logic signed [ERR_W-1:0]   err3_x_reg;
    logic signed [ERR_W-1:0]   err3_y_reg;
    logic signed [ACC_W-1:0]   acc_x_reg;
    logic signed [ACC_W-1:0]   acc_y_reg;
    logic signed [ERR_W:0]     diff_x_reg;
    logic signed [ERR_W:0]     diff_y_reg;
    logic signed [DRIVE_W-1:0] drive_x_reg;
    logic signed [DRIVE_W-1:0] drive_y_reg;

    logic signed [ERR_W-1:0]   err_x;
    logic signed [ERR_W-1:0]   err_y;
    logic signed [ACC_W-1:0]   acc_x;
    logic signed [ACC_W-1:0]   acc_y;
    logic signed [ERR_W:0]     diff_x;
    logic signed [ERR_W:0]     diff_y;
    logic signed [DRIVE_W-1:0] drv_x;
    logic signed [DRIVE_W-1:0] drv_y;

    logic out_free, rdy4, rdy3, rdy2, rdy1;
    logic adv1, adv2, adv3, adv4, item_take;
    dapid_ctrl_t ctrl;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            target_x_reg <= PIXEL_BITS'(TARGET_RESET);
            target_y_reg <= PIXEL_BITS'(TARGET_RESET);
            limit_reg    <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_P:       gain_p_reg   <= cfg_data;
                REG_GAIN_I:       gain_i_reg   <= cfg_data;
                REG_GAIN_D:       gain_d_reg   <= cfg_data;
                REG_TARGET_X:     target_x_reg <= cfg_data[PIXEL_BITS-1:0];
                REG_TARGET_Y:     target_y_reg <= cfg_data[PIXEL_BITS-1:0];
                REG_OUTPUT_LIMIT: limit_reg    <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    always_comb
    begin
        out_free  = !out_valid_reg || result_ready;
        rdy4      = !v4_reg || out_free;
        rdy3      = !v3_reg || rdy4;
        rdy2      = !v2_reg || rdy3;
        rdy1      = !v1_reg || rdy2;
        adv4      = v4_reg && out_free;
        adv3      = v3_reg && rdy4;
        adv2      = v2_reg && rdy3;
        adv1      = v1_reg && rdy2;
        item_take = item_valid && rdy1;

        v1_next        = item_take || (v1_reg && !adv1);
        v2_next        = adv1 || (v2_reg && !adv2);
        v3_next        = adv2 || (v3_reg && !adv3);
        v4_next        = adv3 || (v4_reg && !adv4);
        out_valid_next = adv4 || (out_valid_reg && !result_ready);

        ctrl.step_state = adv2;
        ctrl.load_prod  = adv3;
    end

    assign item_ready   = rdy1;
    assign result_valid = out_valid_reg;
    assign drive_x      = drive_x_reg;
    assign drive_y      = drive_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- datapath ----------------
    dapid_err #(.PIXEL_BITS(PIXEL_BITS)) u_err_x (
        .pixel  (ball_x_reg),
        .target (target_x_reg),
        .offset (offset_x_reg),
        .err    (err_x)
    );

    dapid_err #(.PIXEL_BITS(PIXEL_BITS)) u_err_y (
        .pixel  (ball_y_reg),
        .target (target_y_reg),
        .offset (offset_y_reg),
        .err    (err_y)
    );

    dapid_integ u_integ_x (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .err   (err2_x_reg),
        .acc   (acc_x),
        .diff  (diff_x)
    );

    dapid_integ u_integ_y (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .err   (err2_y_reg),
        .acc   (acc_y),
        .diff  (diff_y)
    );

    dapid_drive u_drive_x (
        .clk    (clk),
        .ctrl   (ctrl),
        .gain_p (gain_p_reg),
        .gain_i (gain_i_reg),
        .gain_d (gain_d_reg),
        .err    (err3_x_reg),
        .acc    (acc_x_reg),
        .diff   (diff_x_reg),
        .limit  (limit_reg),
        .drive  (drv_x)
    );

    dapid_drive u_drive_y (
        .clk    (clk),
        .ctrl   (ctrl),
        .gain_p (gain_p_reg),
        .gain_i (gain_i_reg),
        .gain_d (gain_d_reg),
        .err    (err3_y_reg),
        .acc    (acc_y_reg),
        .diff   (diff_y_reg),
        .limit  (limit_reg),
        .drive  (drv_y)
    );

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            ball_x_reg   <= ball_x;
            ball_y_reg   <= ball_y;
            offset_x_reg <= offset_x;
            offset_y_reg <= offset_y;
        end
        if (adv1)
        begin
            err2_x_reg <= err_x;
            err2_y_reg <= err_y;
        end
        if (adv2)
        begin
            err3_x_reg <= err2_x_reg;
            err3_y_reg <= err2_y_reg;
            acc_x_reg  <= acc_x;
            acc_y_reg  <= acc_y;
            diff_x_reg <= diff_x;
            diff_y_reg <= diff_y;
        end
        if (adv4)
        begin
            drive_x_reg <= drv_x;
            drive_y_reg <= drv_y;
        end
    end

    // ---------------- assertions ----------------
    `AST_NEXT(a_take_fills_input, item_valid && item_ready, v1_reg,
              "accepted item not captured")
    `AST_SAME(a_stall_only_when_full, !item_ready,
              v1_reg && v2_reg && v3_reg && v4_reg && result_valid && !result_ready,
              "item channel stalled with a free stage")
    `AST_SAME(a_result_not_dropped, $fell(result_valid), $past(result_ready),
              "result dropped before transaction")
    `AST_NEXT(a_state_step_moves, ctrl.step_state, v3_reg,
              "integral updated without advancing the item")

endmodule

`default_nettype wire
